// ----- hw/rtl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and the control program of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int DATA_W    = 32;
  localparam int GAIN_FRAC = 16;
  localparam int GAIN_W    = GAIN_FRAC + 1;
  localparam int PROD_W    = DATA_W + GAIN_W;
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_FRAC - 1);

  localparam logic [DATA_W-1:0] Q_RESET  = DATA_W'(1180);
  localparam logic [DATA_W-1:0] R_RESET  = DATA_W'(101057);
  localparam logic [DATA_W-1:0] P0_RESET = DATA_W'(1311);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COV   = CFG_IDX_W'(2);

  localparam logic [STEP_W-1:0] STEP_ACCEPT   = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_RESTART  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_PRIOR    = STEP_W'(2);
  localparam logic [STEP_W-1:0] STEP_DIV_INIT = STEP_W'(3);
  localparam logic [STEP_W-1:0] STEP_DIV_STEP = STEP_W'(4);
  localparam logic [STEP_W-1:0] STEP_GAIN     = STEP_W'(5);
  localparam logic [STEP_W-1:0] STEP_MUL_EST  = STEP_W'(6);
  localparam logic [STEP_W-1:0] STEP_EST      = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_COV      = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_PUBLISH  = STEP_W'(9);

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_RESTART,
    OP_PRIOR,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_GAIN,
    OP_MUL_EST,
    OP_EST,
    OP_COV,
    OP_PUBLISH
  } op_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_SAMPLE,
    WAIT_OUT
  } wait_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_DIV_MORE
  } jmp_t;

  typedef enum logic {
    MUL_EST,
    MUL_COV
  } mul_sel_t;

  typedef struct packed {
    op_t               op;
    wait_t             wait_on;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    mul_sel_t          mul_sel;
  } ucode_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t mul_sel;
    logic     go;
  } step_t;

  typedef struct packed {
    logic sample_valid;
    logic out_free;
  } seq_status_t;

  function automatic ucode_t ucode(input logic [STEP_W-1:0] addr);
    ucode_t w;
    w = '{op: OP_NOP, wait_on: WAIT_NONE, jmp: JMP_ALWAYS, target: STEP_ACCEPT,
          mul_sel: MUL_EST};
    case (addr)
      STEP_ACCEPT: begin
        w.op      = OP_ACCEPT;
        w.wait_on = WAIT_SAMPLE;
        w.jmp     = JMP_NONE;
      end
      STEP_RESTART: begin
        w.op  = OP_RESTART;
        w.jmp = JMP_NONE;
      end
      STEP_PRIOR: begin
        w.op  = OP_PRIOR;
        w.jmp = JMP_NONE;
      end
      STEP_DIV_INIT: begin
        w.op  = OP_DIV_INIT;
        w.jmp = JMP_NONE;
      end
      STEP_DIV_STEP: begin
        w.op     = OP_DIV_STEP;
        w.jmp    = JMP_DIV_MORE;
        w.target = STEP_DIV_STEP;
      end
      STEP_GAIN: begin
        w.op  = OP_GAIN;
        w.jmp = JMP_NONE;
      end
      STEP_MUL_EST: begin
        w.op      = OP_MUL_EST;
        w.jmp     = JMP_NONE;
        w.mul_sel = MUL_EST;
      end
      STEP_EST: begin
        w.op      = OP_EST;
        w.jmp     = JMP_NONE;
        w.mul_sel = MUL_COV;
      end
      STEP_COV: begin
        w.op  = OP_COV;
        w.jmp = JMP_NONE;
      end
      STEP_PUBLISH: begin
        w.op      = OP_PUBLISH;
        w.wait_on = WAIT_OUT;
        w.jmp     = JMP_ALWAYS;
        w.target  = STEP_ACCEPT;
      end
      default: begin
        w.op  = OP_NOP;
        w.jmp = JMP_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/skf_seq.sv -----
// ----------------------------------------------------------------------------
// skf_seq
// Step counter, control store and loop counter of the filter sequencer.
// ----------------------------------------------------------------------------
module skf_seq (
  input  logic                clk,
  input  logic                rst,
  input  skf_pkg::seq_status_t status,
  output skf_pkg::step_t      step
);
  import skf_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  ucode_t            word;
  logic              waiting;

  assign word = ucode(pc);

  always_comb begin
    case (word.wait_on)
      WAIT_SAMPLE: waiting = !status.sample_valid;
      WAIT_OUT:    waiting = !status.out_free;
      default:     waiting = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = pc + STEP_W'(1);
    if (waiting) begin
      pc_next = pc;
    end else begin
      case (word.jmp)
        JMP_ALWAYS:   pc_next = word.target;
        JMP_DIV_MORE: if (cnt != '0) pc_next = word.target;
        default:      pc_next = pc + STEP_W'(1);
      endcase
    end
  end

  always_comb begin
    cnt_next = cnt;
    case (word.op)
      OP_DIV_INIT: cnt_next = CNT_W'(DIV_STEPS - 1);
      OP_DIV_STEP: if (cnt != '0) cnt_next = cnt - CNT_W'(1);
      default:     cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= STEP_ACCEPT;
      cnt <= '0;
    end else begin
      pc  <= pc_next;
      cnt <= cnt_next;
    end
  end

  assign step.op      = word.op;
  assign step.mul_sel = word.mul_sel;
  assign step.go      = !waiting;

endmodule

// ----- hw/rtl/scalar_kalman_filter_core.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional Kalman filter on signed Q16.16 samples, microcoded datapath.
// ----------------------------------------------------------------------------
// Each sample holds the sequencer through one acceptance step, three set-up
// steps, seventeen passes of the radix-2 restoring divider that forms the
// Q1.16 gain, and five steps that latch the gain, share one 32x17 multiplier
// for the estimate and covariance updates and then load the result register.
// The sequencer then returns to its acceptance step, so a new sample is not
// taken until the previous one has passed through every step. A result still
// stalled downstream holds the load step until it leaves. A new sample is
// taken as soon as the sequencer returns to its acceptance step, even while
// the previous result still waits downstream.
// The first sample after reset or after a sample marked last restarts the
// filter from that sample and the initial covariance. Configuration writes are
// always ready; write them only while no transaction is in flight.
module scalar_kalman_filter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]             cfg_data,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [skf_pkg::DATA_W-1:0]      measurement,
  input  logic                                   last,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output logic signed [skf_pkg::DATA_W-1:0]      estimate,
  output logic [skf_pkg::DATA_W-1:0]             covariance,
  output logic [skf_pkg::GAIN_W-1:0]             gain,
  output logic                                   done_res
);
  import skf_pkg::*;

  logic [DATA_W-1:0]        process_noise;
  logic [DATA_W-1:0]        measure_noise;
  logic [DATA_W-1:0]        initial_cov;

  logic signed [DATA_W-1:0] z;
  logic                     last_q;
  logic signed [DATA_W-1:0] est;
  logic [DATA_W-1:0]        cov;
  logic                     restart;
  logic [DATA_W-1:0]        p;
  logic [DATA_W:0]          denom;
  logic                     dzero;
  logic [DATA_W:0]          rem;
  logic [GAIN_W-1:0]        dq;
  logic [GAIN_W-1:0]        gain_q;
  logic                     neg;
  logic [DATA_W-1:0]        mag;
  logic [PROD_W-1:0]        prod;

  logic [DATA_W:0]          prior_sum;
  logic [DATA_W-1:0]        prior_calc;
  logic [DATA_W:0]          denom_calc;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          trial;
  logic [DATA_W+1:0]        trial_sub;
  logic                     trial_ge;
  logic [DATA_W-1:0]        mul_a;
  logic [GAIN_W-1:0]        mul_b;
  logic [PROD_W-1:0]        prod_calc;
  logic [PROD_W-1:0]        prod_round;
  logic [DATA_W-1:0]        step_amt;
  logic signed [DATA_W:0]   est_wide;
  logic signed [DATA_W-1:0] est_calc;
  logic [DATA_W-1:0]        cov_calc;
  logic                     out_free;

  step_t                    step;
  seq_status_t              status;

  assign out_free            = !result_valid || !result_stall;
  assign status.sample_valid = sample_valid;
  assign status.out_free     = out_free;

  skf_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .step   (step)
  );

  assign cfg_ready    = 1'b1;
  assign sample_stall = (step.op != OP_ACCEPT);

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= Q_RESET;
      measure_noise <= R_RESET;
      initial_cov   <= P0_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROCESS_NOISE: process_noise <= cfg_data;
        REG_MEASURE_NOISE: measure_noise <= cfg_data;
        REG_INITIAL_COV:   initial_cov   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign prior_sum  = {1'b0, cov} + {1'b0, process_noise};
  assign prior_calc = prior_sum[DATA_W] ? '1 : prior_sum[DATA_W-1:0];
  assign denom_calc = {1'b0, p} + {1'b0, measure_noise};
  assign diff       = {z[DATA_W-1], z} - {est[DATA_W-1], est};

  assign trial     = {rem[DATA_W-1:0], dq[GAIN_W-1]};
  assign trial_sub = {1'b0, trial} - {1'b0, denom};
  assign trial_ge  = rem[DATA_W] || !trial_sub[DATA_W+1];

  assign mul_a     = (step.mul_sel == MUL_COV) ? p : mag;
  assign mul_b     = (step.mul_sel == MUL_COV) ? (GAIN_ONE - gain_q) : gain_q;
  assign prod_calc = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign prod_round = prod + ROUND_HALF;
  assign step_amt   = prod_round[GAIN_FRAC +: DATA_W];
  assign cov_calc   = prod_round[GAIN_FRAC +: DATA_W];
  assign est_wide   = neg ? ({est[DATA_W-1], est} - {1'b0, step_amt})
                          : ({est[DATA_W-1], est} + {1'b0, step_amt});
  assign est_calc   = est_wide[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b1;
    end else if (step.go) begin
      case (step.op)
        OP_RESTART: restart <= 1'b0;
        OP_COV:     if (last_q) restart <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est <= '0;
      cov <= '0;
    end else if (step.go) begin
      case (step.op)
        OP_RESTART: begin
          if (restart) begin
            est <= z;
            cov <= initial_cov;
          end
        end
        OP_EST:  est <= est_calc;
        OP_COV:  cov <= cov_calc;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step.go) begin
      case (step.op)
        OP_ACCEPT: begin
          z      <= measurement;
          last_q <= last;
        end
        OP_PRIOR: p <= prior_calc;
        OP_DIV_INIT: begin
          denom <= denom_calc;
          dzero <= (denom_calc == '0);
          rem   <= {2'b00, p[DATA_W-1:1]};
          dq    <= {p[0], {(GAIN_W-1){1'b0}}};
          neg   <= diff[DATA_W];
          mag   <= diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
        end
        OP_DIV_STEP: begin
          rem <= trial_ge ? trial_sub[DATA_W:0] : trial;
          dq  <= {dq[GAIN_W-2:0], trial_ge};
        end
        OP_GAIN:    gain_q <= dzero ? '0 : dq;
        OP_MUL_EST: prod   <= prod_calc;
        OP_EST:     prod   <= prod_calc;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step.go && step.op == OP_PUBLISH) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.go && step.op == OP_PUBLISH) begin
      estimate   <= est;
      covariance <= cov;
      gain       <= gain_q;
      done_res   <= last_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (step.op == OP_DIV_STEP && !dzero) |-> (rem < denom))
    else $error("divider remainder not below divisor");

  a_gain_in_range: assert property (@(posedge clk) disable iff (rst)
    (step.go && step.op == OP_GAIN) |=> (gain_q <= GAIN_ONE))
    else $error("gain above one");

  a_est_between: assert property (@(posedge clk) disable iff (rst)
    (step.go && step.op == OP_EST) |->
      (neg ? (est_calc >= z && est_calc <= est) : (est_calc >= est && est_calc <= z)))
    else $error("estimate left the span between prior and sample");

  a_cov_not_above_prior: assert property (@(posedge clk) disable iff (rst)
    (step.go && step.op == OP_COV) |-> (cov_calc <= p))
    else $error("posterior covariance above prior");
`endif

endmodule
